// ===== rtl/core/depth_ordered_entry_list_macros.svh =====
// ----------------------------------------------------------------------------
// depth ordered entry list assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef DEPTH_ORDERED_ENTRY_LIST_MACROS_SVH
`define DEPTH_ORDERED_ENTRY_LIST_MACROS_SVH

// consequent holds in the same cycle
`define DEL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the next cycle
`define DEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/del_pkg.sv =====
// ----------------------------------------------------------------------------
// del_pkg
// shared types, codes and widths of the depth ordered entry list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package del_pkg;

  localparam int CAPACITY_DEFAULT = 32;

  localparam int REQ_W      = 2;
  localparam int HANDLE_W   = 8;
  localparam int DEPTH_W    = 16;
  localparam int RPOS_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 6;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 40;
  localparam int OUT_USED_W = STATUS_W + POS_W + HANDLE_W + DEPTH_W + COUNT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_CHANGE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_READ,
    S_NOP
  } state_t;

  typedef enum logic [1:0] {
    RES_INSERT,
    RES_READ,
    RES_NOP
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     remove;
    logic     commit;
    res_sel_t res_sel;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/del_ctrl.sv =====
// ----------------------------------------------------------------------------
// del_ctrl
// request sequencer: accepts a word, runs remove and insert passes, hands off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "depth_ordered_entry_list_macros.svh"

module del_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [del_pkg::REQ_W-1:0]    req_type,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output del_pkg::cmd_t                     cmd
);

  del_pkg::state_t state, state_next;
  logic            out_valid;
  logic            slot_free;

  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == del_pkg::S_IDLE);
  assign m_tvalid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= del_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.remove  = 1'b0;
    cmd.commit  = 1'b0;
    cmd.res_sel = del_pkg::RES_NOP;
    unique case (state) inside
      del_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          unique case (del_pkg::req_t'(req_type))
            del_pkg::REQ_INSERT: state_next = del_pkg::S_INSERT;
            del_pkg::REQ_CHANGE: state_next = del_pkg::S_REMOVE;
            del_pkg::REQ_READ:   state_next = del_pkg::S_READ;
            default:             state_next = del_pkg::S_NOP;
          endcase
        end
      end
      del_pkg::S_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = del_pkg::S_INSERT;
      end
      del_pkg::S_INSERT, del_pkg::S_READ, del_pkg::S_NOP: begin
        if (state == del_pkg::S_INSERT) begin
          cmd.res_sel = del_pkg::RES_INSERT;
        end else if (state == del_pkg::S_READ) begin
          cmd.res_sel = del_pkg::RES_READ;
        end
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = del_pkg::S_IDLE;
        end
      end
      default: state_next = del_pkg::S_IDLE;
    endcase
  end

  `DEL_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid || m_tready)
  `DEL_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state != del_pkg::S_IDLE)
  `DEL_ASSERT_NEXT(a_commit_shows_word, cmd.commit, m_tvalid)
  `DEL_ASSERT_NEXT(a_remove_then_insert, cmd.remove, state == del_pkg::S_INSERT)

endmodule

`default_nettype wire

// ===== rtl/core/del_datapath.sv =====
// ----------------------------------------------------------------------------
// del_datapath
// sorted row of depth and handle cells with parallel compare and shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "depth_ordered_entry_list_macros.svh"

module del_datapath #(
  parameter int CAPACITY = del_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire del_pkg::cmd_t               cmd,
  input  wire logic [del_pkg::IN_W-1:0]    s_tdata,
  output logic [del_pkg::OUT_W-1:0]        m_tdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = CW + del_pkg::RPOS_W;

  logic signed [del_pkg::DEPTH_W-1:0]  cell_depth [CAPACITY];
  logic        [del_pkg::HANDLE_W-1:0] cell_handle [CAPACITY];
  logic        [CW-1:0]                count;

  logic signed [del_pkg::DEPTH_W-1:0]  req_depth;
  logic        [del_pkg::HANDLE_W-1:0] req_handle;
  logic        [del_pkg::RPOS_W-1:0]   req_rpos;

  logic [CAPACITY-1:0] valid_v, at_end, gt, prev_gt, place, match, below;
  logic signed [del_pkg::DEPTH_W-1:0]  lower_depth [CAPACITY];
  logic        [del_pkg::HANDLE_W-1:0] lower_handle [CAPACITY];
  logic signed [del_pkg::DEPTH_W-1:0]  upper_depth [CAPACITY];
  logic        [del_pkg::HANDLE_W-1:0] upper_handle [CAPACITY];

  logic [IW-1:0]               ins_pos;
  logic [IW-1:0]               rd_idx;
  logic                        full, found, in_range, ins_en;
  del_pkg::status_t            res_status;
  logic [del_pkg::POS_W-1:0]   res_pos;
  logic [del_pkg::HANDLE_W-1:0] res_handle;
  logic [del_pkg::DEPTH_W-1:0] res_depth;
  logic [CW-1:0]               res_count;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_v[i] = (CW'(i) < count);
    assign at_end[i]  = (CW'(i) == count);
    assign gt[i]      = valid_v[i] && (cell_depth[i] > req_depth);
    assign match[i]   = valid_v[i] && (cell_handle[i] == req_handle);
    assign place[i]   = (gt[i] || at_end[i]) && !prev_gt[i];
    if (i == 0) begin : g_lo
      assign prev_gt[i]      = 1'b0;
      assign lower_depth[i]  = cell_depth[i];
      assign lower_handle[i] = cell_handle[i];
    end else begin : g_mid_lo
      assign prev_gt[i]      = gt[i-1];
      assign lower_depth[i]  = cell_depth[i-1];
      assign lower_handle[i] = cell_handle[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign upper_depth[i]  = cell_depth[i];
      assign upper_handle[i] = cell_handle[i];
    end else begin : g_mid_hi
      assign upper_depth[i]  = cell_depth[i+1];
      assign upper_handle[i] = cell_handle[i+1];
    end
  end

  // cells strictly below the first matching handle stay put
  assign below = (match - CAPACITY'(1)) & ~match;
  assign found = |match;

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (place[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  assign full     = (count >= CW'(CAPACITY));
  assign ins_en   = cmd.commit && (cmd.res_sel == del_pkg::RES_INSERT) && !full;
  assign in_range = (MW'(req_rpos) < MW'(count));
  assign rd_idx   = IW'(req_rpos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_handle <= s_tdata[9:2];
      req_depth  <= s_tdata[25:10];
      req_rpos   <= s_tdata[30:26];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.remove && !below[i]) begin
        cell_depth[i]  <= upper_depth[i];
        cell_handle[i] <= upper_handle[i];
      end else if (ins_en && prev_gt[i]) begin
        cell_depth[i]  <= lower_depth[i];
        cell_handle[i] <= lower_handle[i];
      end else if (ins_en && place[i]) begin
        cell_depth[i]  <= req_depth;
        cell_handle[i] <= req_handle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.remove) begin
      count <= count - CW'(found);
    end else if (ins_en) begin
      count <= count + CW'(1);
    end
  end

  always_comb begin
    res_status = del_pkg::ST_OK;
    res_pos    = '0;
    res_handle = req_handle;
    res_depth  = req_depth;
    res_count  = count;
    case (cmd.res_sel)
      del_pkg::RES_INSERT: begin
        if (full) begin
          res_status = del_pkg::ST_FULL;
          res_pos    = del_pkg::POS_W'(CAPACITY);
        end else begin
          res_pos   = del_pkg::POS_W'(ins_pos);
          res_count = count + CW'(1);
        end
      end
      del_pkg::RES_READ: begin
        res_pos = del_pkg::POS_W'(req_rpos);
        if (in_range) begin
          res_handle = cell_handle[rd_idx];
          res_depth  = cell_depth[rd_idx];
        end else begin
          res_status = del_pkg::ST_BEYOND;
          res_handle = '0;
          res_depth  = '0;
        end
      end
      default: begin
        res_pos = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {(del_pkg::OUT_W - del_pkg::OUT_USED_W)'(0),
                  del_pkg::COUNT_W'(res_count), res_depth, res_handle, res_pos,
                  res_status};
    end
  end

  `DEL_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `DEL_ASSERT_NOW(a_no_remove_on_commit, cmd.remove, !cmd.commit && !cmd.load)

endmodule

`default_nettype wire

// ===== rtl/core/depth_ordered_entry_list.sv =====
// ----------------------------------------------------------------------------
// depth_ordered_entry_list
// handle and depth table kept in ascending, stable depth order
// ----------------------------------------------------------------------------
// One request word is taken at a time and answers with exactly one word. An
// insert or a read has its answer registered from the insert or read state
// after it is taken, a depth change from the insert state after a remove
// state, since the row of cells moves at most once per cycle: one pass
// closes the gap left by the removed handle, the next opens the slot for the
// new pair. All cells compare their depth or handle in parallel within a
// pass. A new word is taken in the cycle after the answer is registered,
// even while that answer still waits on m_tready. A further answer is held
// back only while the previous one has not been taken. No clearing pass after
// reset.
`timescale 1ns / 1ps
`default_nettype none

module depth_ordered_entry_list #(
  parameter int CAPACITY = del_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // req_type[1:0], entry_handle[9:2], new_depth[25:10], read_position[30:26]
  input  wire logic [del_pkg::IN_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // status[1:0], placed_position[7:2], out_handle[15:8], out_depth[31:16],
  // entry_count[37:32]
  output logic [del_pkg::OUT_W-1:0]        m_tdata
);

  del_pkg::cmd_t cmd;

  del_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tdata[del_pkg::REQ_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  del_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

`default_nettype wire
